>>> hw/rtl/xbp_pkg.sv
`default_nettype none

package xbp_pkg;

	// Rounds of the permutation; each round is two half-rounds
	localparam int unsigned ROUND_COUNT = 32;
	localparam int unsigned STAGE_COUNT = 2 * ROUND_COUNT;

	// Golden-ratio delta and the sum an inverse pass starts from
	localparam logic [31:0] PERM_DELTA = 32'h9E37_79B9;
	localparam logic [63:0] INV_SUM_PROD = 64'(ROUND_COUNT) * 64'(PERM_DELTA);
	localparam logic [31:0] INV_SUM_INIT = INV_SUM_PROD[31:0];

	// Direction codes
	localparam logic OP_FORWARD = 1'b0;
	localparam logic OP_INVERSE = 1'b1;

	typedef struct packed {
		logic        opcode;
		logic [31:0] first_word;
		logic [31:0] second_word;
	} xbp_in_t;

	typedef struct packed {
		logic [31:0] first_word_out;
		logic [31:0] second_word_out;
	} xbp_out_t;

	// Keyless XTEA round function
	function automatic logic [31:0] mix_word(input logic [31:0] x, input logic [31:0] sum);
		logic [31:0] sh;
		sh = (x << 4) ^ (x >> 5);
		return (sh + x) ^ sum;
	endfunction

	// Forward running sum used by half-round stage j: ceil(j/2) deltas
	function automatic logic [31:0] stage_sum(input int unsigned j);
		logic [63:0] prod;
		prod = 64'((j + 1) >> 1) * 64'(PERM_DELTA);
		return prod[31:0];
	endfunction

endpackage

`default_nettype wire

>>> hw/rtl/keyless_xtea_block_permutation_unit.sv
`default_nettype none

// Keyless XTEA block permutation: each item carries two 32-bit words and a
// direction bit (forward or inverse); the block returns the two words after
// ROUND_COUNT keyless XTEA rounds, the inverse undoing the forward exactly.
// Every half-round has its own pipeline stage, so there are 2*ROUND_COUNT
// stages (64 for 32 rounds) plus an output register, and one item is
// accepted in every cycle while the skid register is empty. A skid register
// behind the last stage takes the item the pipeline still pushes out after
// out_ready drops; in_ready falls only once that skid register holds an
// item, and is driven from a register.
module keyless_xtea_block_permutation_unit (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             in_valid,
	output logic                  in_ready,
	input  wire xbp_pkg::xbp_in_t in_item,
	output logic                  out_valid,
	input  wire logic             out_ready,
	output xbp_pkg::xbp_out_t     out_item
);
	import xbp_pkg::*;

	typedef struct packed {
		logic        op;
		logic [31:0] w0;
		logic [31:0] w1;
	} stage_t;

	stage_t   pipe_s [STAGE_COUNT];
	logic     vld_s  [STAGE_COUNT];

	logic     advance;
	logic     out_vld_q;
	xbp_out_t out_item_q;
	logic     skid_vld_q;
	xbp_out_t skid_q;
	logic     push;
	logic     pop;
	xbp_out_t last_item;

	// Whole pipeline moves while the skid register is free
	assign advance  = !skid_vld_q;
	assign in_ready = advance;

	// Half-round stages
	for (genvar j = 0; j < STAGE_COUNT; j++) begin : g_stage
		localparam logic [31:0] FWD_SUM  = stage_sum(j);
		localparam logic [31:0] INV_SUM  = INV_SUM_INIT - FWD_SUM;
		localparam bit          HALF_ONE = (j % 2) == 1;

		stage_t      prev;
		logic        prev_vld;
		logic        inv;
		logic        use_w1;
		logic [31:0] src;
		logic [31:0] tgt;
		logic [31:0] mixed;
		logic [31:0] upd;
		stage_t      nxt;

		if (j == 0) begin : g_head
			assign prev     = '{op: in_item.opcode, w0: in_item.first_word,
			                    w1: in_item.second_word};
			assign prev_vld = in_valid;
		end else begin : g_body
			assign prev     = pipe_s[j-1];
			assign prev_vld = vld_s[j-1];
		end

		// forward: first half updates w0 from w1, second half w1 from w0;
		// inverse runs the halves mirrored
		always_comb begin
			inv    = (prev.op == OP_INVERSE);
			use_w1 = (!HALF_ONE) ^ inv;
			src    = use_w1 ? prev.w1 : prev.w0;
			tgt    = use_w1 ? prev.w0 : prev.w1;
			mixed  = mix_word(src, inv ? INV_SUM : FWD_SUM);
			upd    = inv ? (tgt - mixed) : (tgt + mixed);
			nxt    = prev;
			if (use_w1) begin
				nxt.w0 = upd;
			end else begin
				nxt.w1 = upd;
			end
		end

		always_ff @(posedge clk) begin
			if (advance) begin
				pipe_s[j] <= nxt;
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[j] <= 1'b0;
			end else if (advance) begin
				vld_s[j] <= prev_vld;
			end
		end
	end

	assign last_item = '{first_word_out: pipe_s[STAGE_COUNT-1].w0,
	                     second_word_out: pipe_s[STAGE_COUNT-1].w1};
	assign push = vld_s[STAGE_COUNT-1] && advance;
	assign pop  = out_vld_q && out_ready;

	// Output register with skid slot
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q  <= 1'b0;
			skid_vld_q <= 1'b0;
		end else if (skid_vld_q) begin
			if (pop) begin
				skid_vld_q <= 1'b0;
			end
		end else if (push) begin
			if (out_vld_q && !pop) begin
				skid_vld_q <= 1'b1;
			end else begin
				out_vld_q <= 1'b1;
			end
		end else if (pop) begin
			out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (skid_vld_q) begin
			if (pop) begin
				out_item_q <= skid_q;
			end
		end else if (push) begin
			if (out_vld_q && !pop) begin
				skid_q <= last_item;
			end else begin
				out_item_q <= last_item;
			end
		end
	end

	assign out_valid = out_vld_q;
	assign out_item  = out_item_q;

endmodule

`default_nettype wire

>>> hw/rtl/xbp_checker.sv
`default_nettype none

module xbp_checker (
	input wire logic              clk,
	input wire logic              arst_n,
	input wire logic              in_valid,
	input wire logic              in_ready,
	input wire logic              out_valid,
	input wire logic              out_ready,
	input wire xbp_pkg::xbp_out_t out_item
);
	import xbp_pkg::*;

	// A held result stays offered
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result dropped while stalled");

	// A held result keeps its payload
	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(out_item))
		else $error("result payload changed while stalled");

	// Backpressure only while a result waits
	a_stall_has_out: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> out_valid)
		else $error("input stalled with no result waiting");

	// Input stalls only after a result was refused
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(in_ready) |-> $past(out_valid && !out_ready))
		else $error("input stalled without a refused result");

	// Stall clears only after a result was taken
	a_stall_release: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(in_ready) |-> $past(out_valid && out_ready))
		else $error("input stall released without a taken result");

endmodule

bind keyless_xtea_block_permutation_unit xbp_checker u_xbp_checker (.*);

`default_nettype wire
